[hw/rtl/gmc_pkg.sv]
// gmc_pkg: shared constants and types for the grid monotone chain DP core.
// No dependencies; used by grid_monotone_chain_dp_core.
package gmc_pkg;

    localparam int DEF_MAX_POINTS = 32;

    localparam int VAL_W   = 17;   // stored cell index width
    localparam int CELL_W  = 16;   // emitted cell index width
    localparam int WAYS_W  = 32;
    localparam int PTS_W   = 6;
    localparam int RANK_W  = 8;
    localparam int GRID_W  = 8;
    localparam int DIV_STEPS = VAL_W;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_CELL    = 1'b1;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SENT0,
        S_SORT_I,
        S_SORT_V,
        S_SORT_CMP,
        S_SORT_PUT,
        S_RK_RD,
        S_RK_LD,
        S_RK_DIV,
        S_DP_I,
        S_DP_LI,
        S_DP_J,
        S_BT_RD0,
        S_BT_L0,
        S_BT_RD,
        S_BT_WR,
        S_EM_WAIT,
        S_EM_LD
    } t_state;

endpackage

[hw/rtl/grid_monotone_chain_dp_core.sv]
// Add word: accepted, no result. Finish word: writes both sentinels, then runs an
// insertion sort, a column rank pass over every entry (one bit of a shared
// restoring divider per cycle), the DP, a backtrack over the chain points, and
// then emits the summary and cell words.
// One word at a time.
// Reset (sync, active low): grid 1x1, empty point set, flags clear, idle.
// Depends on gmc_pkg.
module grid_monotone_chain_dp_core #(
    parameter int MAX_POINTS = gmc_pkg::DEF_MAX_POINTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] point_row, [15:8] point_col
    input  logic        s_axis_tuser,   // [0] opcode
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [5:0] chain_points, [37:6] chain_ways,
                                        // [38] overflowed, [54:39] cell_index
    output logic        m_axis_tuser,   // [0] item_kind
    output logic        m_axis_tlast,   // last_item
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOTS = MAX_POINTS + 2;
    localparam int AW    = $clog2(SLOTS);       // entry address
    localparam int CW    = $clog2(SLOTS + 1);   // counts up to SLOTS
    localparam int TW    = $clog2(MAX_POINTS + 1);
    localparam int VW    = gmc_pkg::VAL_W;
    localparam int WW    = gmc_pkg::WAYS_W;
    localparam int RW    = gmc_pkg::RANK_W;
    localparam int DPW   = AW + WW + AW;        // {length, ways, predecessor}

    // ---------------- configuration registers ----------------
    logic [7:0] r_rows, r_cols;
    logic       w_cfg_wr;
    logic [7:0] w_cols;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign prdata   = (paddr[2] == gmc_pkg::REG_COLS) ? {24'd0, r_cols} : {24'd0, r_rows};
    assign w_cols   = (r_cols == 8'd0) ? 8'd1 : r_cols;   // zero columns acts as one

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 8'd1;
            r_cols <= 8'd1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == gmc_pkg::REG_ROWS) r_rows <= pwdata[7:0];
            else                               r_cols <= pwdata[7:0];
        end
    end

    // ---------------- memories ----------------
    // point store, DP record and column rank share one read address.
    logic [VW-1:0]     m_store [SLOTS];
    logic [DPW-1:0]    m_dp    [SLOTS];
    logic [RW-1:0]     m_rank  [SLOTS];
    logic [gmc_pkg::CELL_W-1:0] m_chain [SLOTS];

    logic [AW-1:0]     w_raddr, w_ch_raddr;
    logic              w_st_we, w_dp_we, w_rk_we, w_ch_we;
    logic [AW-1:0]     w_st_waddr, w_dp_waddr, w_rk_waddr, w_ch_waddr;
    logic [VW-1:0]     w_st_wdata;
    logic [DPW-1:0]    w_dp_wdata;
    logic [RW-1:0]     w_rk_wdata;
    logic [gmc_pkg::CELL_W-1:0] w_ch_wdata;

    logic [VW-1:0]     r_st_q;
    logic [DPW-1:0]    r_dp_q;
    logic [RW-1:0]     r_rk_q;
    logic [gmc_pkg::CELL_W-1:0] r_ch_q;

    always_ff @(posedge i_clk) begin
        if (w_st_we) m_store[w_st_waddr] <= w_st_wdata;
        r_st_q <= m_store[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_dp_we) m_dp[w_dp_waddr] <= w_dp_wdata;
        r_dp_q <= m_dp[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rk_we) m_rank[w_rk_waddr] <= w_rk_wdata;
        r_rk_q <= m_rank[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ch_we) m_chain[w_ch_waddr] <= w_ch_wdata;
        r_ch_q <= m_chain[w_ch_raddr];
    end

    // DP record read fields
    logic [AW-1:0] w_q_len, w_q_pred;
    logic [WW-1:0] w_q_ways;
    assign w_q_len  = r_dp_q[DPW-1 -: AW];
    assign w_q_ways = r_dp_q[AW +: WW];
    assign w_q_pred = r_dp_q[AW-1:0];

    // ---------------- control and datapath registers ----------------
    gmc_pkg::t_state r_state, n_state;
    logic [TW-1:0] r_total, n_total;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_n, n_n;          // entries including sentinels
    logic [CW-1:0] r_i, n_i;          // outer index (sort, rank, DP)
    logic [CW-1:0] r_j, n_j;          // inner index
    logic [CW-1:0] r_cnt, n_cnt;      // chain length / emit countdown
    logic [AW-1:0] r_k, n_k;          // backtrack cursor
    logic [VW-1:0] r_v, n_v;          // sort key
    logic [VW-1:0] r_div, n_div;      // divider dividend shift
    logic [RW-1:0] r_rem, n_rem;      // divider remainder
    logic [4:0]    r_bit, n_bit;
    logic [AW-1:0] r_li, n_li;
    logic [WW-1:0] r_wi, n_wi;
    logic [RW-1:0] r_ci, n_ci;
    logic          r_ovalid, n_ovalid;
    logic          r_o_kind, n_o_kind;
    logic [gmc_pkg::PTS_W-1:0] r_o_pts, n_o_pts;
    logic [WW-1:0] r_o_ways, n_o_ways;
    logic          r_o_ovf, n_o_ovf;
    logic [gmc_pkg::CELL_W-1:0] r_o_cell, n_o_cell;
    logic          r_o_last, n_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gmc_pkg::S_IDLE;
            r_total  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_i      <= n_i;
        r_j      <= n_j;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_v      <= n_v;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_li     <= n_li;
        r_wi     <= n_wi;
        r_ci     <= n_ci;
        r_o_kind <= n_o_kind;
        r_o_pts  <= n_o_pts;
        r_o_ways <= n_o_ways;
        r_o_ovf  <= n_o_ovf;
        r_o_cell <= n_o_cell;
        r_o_last <= n_o_last;
    end

    // ---------------- combinational helpers ----------------
    logic [7:0]    w_row, w_col;
    logic          w_pt_ok;
    logic [VW-1:0] w_cell, w_end;
    assign w_row   = s_axis_tdata[7:0];
    assign w_col   = s_axis_tdata[15:8];
    assign w_pt_ok = (w_row != 8'd0) && (w_row <= r_rows) &&
                     (w_col != 8'd0) && (w_col <= w_cols);
    // (row-1)*cols + col
    assign w_cell  = VW'(16'(w_row - 8'd1) * 16'(w_cols)) + VW'(w_col);
    // end sentinel (rows+1)*cols, always in the last column
    assign w_end   = VW'(9'({1'b0, r_rows} + 9'd1)) * VW'(w_cols);

    // one restoring divider step: remainder of (v-1) mod cols
    logic [RW:0]   w_rem_sh;
    logic [RW-1:0] w_rem_nx;
    assign w_rem_sh = {r_rem, r_div[VW-1]};
    assign w_rem_nx = (w_rem_sh >= {1'b0, w_cols}) ? RW'(w_rem_sh - {1'b0, w_cols})
                                                    : w_rem_sh[RW-1:0];

    // DP relaxation terms
    logic [AW-1:0] w_li1;
    logic [WW:0]   w_sum;
    logic [WW-1:0] w_sat;
    assign w_li1 = r_li + AW'(1);
    assign w_sum = {1'b0, w_q_ways} + {1'b0, r_wi};
    assign w_sat = w_sum[WW] ? {WW{1'b1}} : w_sum[WW-1:0];

    logic [DPW-1:0] w_dp_init;
    assign w_dp_init = {AW'(0), WW'(1), AW'(0)};

    logic w_s_acc, w_m_acc;
    assign s_axis_tready = (r_state == gmc_pkg::S_IDLE);
    assign w_s_acc = s_axis_tvalid & s_axis_tready;
    assign w_m_acc = r_ovalid & m_axis_tready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_ovf    = r_ovf;
        n_n      = r_n;
        n_i      = r_i;
        n_j      = r_j;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_v      = r_v;
        n_div    = r_div;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_li     = r_li;
        n_wi     = r_wi;
        n_ci     = r_ci;
        n_ovalid = r_ovalid;
        n_o_kind = r_o_kind;
        n_o_pts  = r_o_pts;
        n_o_ways = r_o_ways;
        n_o_ovf  = r_o_ovf;
        n_o_cell = r_o_cell;
        n_o_last = r_o_last;

        w_raddr    = '0;
        w_ch_raddr = '0;
        w_st_we    = 1'b0;
        w_st_waddr = '0;
        w_st_wdata = '0;
        w_dp_we    = 1'b0;
        w_dp_waddr = '0;
        w_dp_wdata = w_dp_init;
        w_rk_we    = 1'b0;
        w_rk_waddr = '0;
        w_rk_wdata = '0;
        w_ch_we    = 1'b0;
        w_ch_waddr = '0;
        w_ch_wdata = '0;

        unique case (r_state)
            gmc_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    if (s_axis_tuser == gmc_pkg::OP_FINISH) begin
                        n_n        = CW'(r_total) + CW'(2);
                        w_st_we    = 1'b1;
                        w_st_waddr = AW'(CW'(r_total) + CW'(1));
                        w_st_wdata = w_end;
                        n_total    = '0;
                        n_state    = gmc_pkg::S_SENT0;
                    end else if (w_pt_ok) begin
                        if (r_total >= TW'(MAX_POINTS)) begin
                            n_ovf = 1'b1;   // capacity full: drop and flag
                        end else begin
                            w_st_we    = 1'b1;
                            w_st_waddr = AW'(CW'(r_total) + CW'(1));
                            w_st_wdata = w_cell;
                            n_total    = r_total + TW'(1);
                        end
                    end
                end
            end
            gmc_pkg::S_SENT0: begin
                w_st_we    = 1'b1;
                w_st_waddr = '0;
                w_st_wdata = '0;
                n_i        = CW'(2);
                n_state    = gmc_pkg::S_SORT_I;
            end
            gmc_pkg::S_SORT_I: begin
                if (r_i >= r_n) begin
                    n_i     = '0;
                    n_state = gmc_pkg::S_RK_RD;
                end else begin
                    w_raddr = AW'(r_i);
                    n_state = gmc_pkg::S_SORT_V;
                end
            end
            gmc_pkg::S_SORT_V: begin
                n_v     = r_st_q;
                n_j     = r_i;
                w_raddr = AW'(r_i - CW'(1));
                n_state = gmc_pkg::S_SORT_CMP;
            end
            gmc_pkg::S_SORT_CMP: begin
                w_st_we    = 1'b1;
                w_st_waddr = AW'(r_j);
                if (r_st_q > r_v) begin
                    w_st_wdata = r_st_q;   // shift up one slot
                    n_j        = r_j - CW'(1);
                    if (r_j - CW'(1) > CW'(1)) begin
                        w_raddr = AW'(r_j - CW'(2));
                    end else begin
                        n_state = gmc_pkg::S_SORT_PUT;
                    end
                end else begin
                    w_st_wdata = r_v;
                    n_i        = r_i + CW'(1);
                    n_state    = gmc_pkg::S_SORT_I;
                end
            end
            gmc_pkg::S_SORT_PUT: begin
                w_st_we    = 1'b1;
                w_st_waddr = AW'(r_j);
                w_st_wdata = r_v;
                n_i        = r_i + CW'(1);
                n_state    = gmc_pkg::S_SORT_I;
            end
            gmc_pkg::S_RK_RD: begin
                if (r_i >= r_n) begin
                    n_i     = '0;
                    n_state = gmc_pkg::S_DP_I;
                end else begin
                    w_raddr = AW'(r_i);
                    n_state = gmc_pkg::S_RK_LD;
                end
            end
            gmc_pkg::S_RK_LD: begin
                if (r_st_q == '0) begin
                    // start sentinel ranks below every column
                    w_rk_we    = 1'b1;
                    w_rk_waddr = AW'(r_i);
                    w_rk_wdata = '0;
                    w_dp_we    = 1'b1;
                    w_dp_waddr = AW'(r_i);
                    n_i        = r_i + CW'(1);
                    n_state    = gmc_pkg::S_RK_RD;
                end else begin
                    n_div   = r_st_q - VW'(1);
                    n_rem   = '0;
                    n_bit   = '0;
                    n_state = gmc_pkg::S_RK_DIV;
                end
            end
            gmc_pkg::S_RK_DIV: begin
                n_rem = w_rem_nx;
                n_div = {r_div[VW-2:0], 1'b0};
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'(gmc_pkg::DIV_STEPS - 1)) begin
                    w_rk_we    = 1'b1;
                    w_rk_waddr = AW'(r_i);
                    w_rk_wdata = w_rem_nx + RW'(1);
                    w_dp_we    = 1'b1;
                    w_dp_waddr = AW'(r_i);
                    n_i        = r_i + CW'(1);
                    n_state    = gmc_pkg::S_RK_RD;
                end
            end
            gmc_pkg::S_DP_I: begin
                if (r_i + CW'(1) >= r_n) begin
                    n_state = gmc_pkg::S_BT_RD0;
                end else begin
                    w_raddr = AW'(r_i);
                    n_j     = r_i + CW'(1);
                    n_state = gmc_pkg::S_DP_LI;
                end
            end
            gmc_pkg::S_DP_LI: begin
                n_li    = w_q_len;
                n_wi    = w_q_ways;
                n_ci    = r_rk_q;
                w_raddr = AW'(r_j);
                n_state = gmc_pkg::S_DP_J;
            end
            gmc_pkg::S_DP_J: begin
                // relax entry j from entry i; the next j is read meanwhile
                w_dp_waddr = AW'(r_j);
                if (r_rk_q >= r_ci) begin
                    if (w_li1 > w_q_len) begin
                        w_dp_we    = 1'b1;
                        w_dp_wdata = {w_li1, r_wi, AW'(r_i)};
                    end else if (w_li1 == w_q_len) begin
                        w_dp_we    = 1'b1;
                        w_dp_wdata = {w_q_len, w_sat, w_q_pred};
                    end
                end
                if (r_j + CW'(1) < r_n) begin
                    n_j     = r_j + CW'(1);
                    w_raddr = AW'(r_j + CW'(1));
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = gmc_pkg::S_DP_I;
                end
            end
            gmc_pkg::S_BT_RD0: begin
                w_raddr = AW'(r_n - CW'(1));
                n_state = gmc_pkg::S_BT_L0;
            end
            gmc_pkg::S_BT_L0: begin
                n_o_pts  = gmc_pkg::PTS_W'(w_q_len - AW'(1));
                n_o_ways = w_q_ways;
                n_k      = w_q_pred;
                n_cnt    = '0;
                n_state  = gmc_pkg::S_BT_RD;
            end
            gmc_pkg::S_BT_RD: begin
                if (r_k == '0) begin
                    n_o_kind = gmc_pkg::KIND_SUMMARY;
                    n_o_ovf  = r_ovf;
                    n_o_cell = '0;
                    n_o_last = (r_cnt == '0);
                    n_ovalid = 1'b1;
                    n_ovf    = 1'b0;
                    n_state  = gmc_pkg::S_EM_WAIT;
                end else begin
                    w_raddr = r_k;
                    n_state = gmc_pkg::S_BT_WR;
                end
            end
            gmc_pkg::S_BT_WR: begin
                // chain collected back to front
                w_ch_we    = 1'b1;
                w_ch_waddr = AW'(r_cnt);
                w_ch_wdata = r_st_q[gmc_pkg::CELL_W-1:0];
                n_cnt      = r_cnt + CW'(1);
                n_k        = w_q_pred;
                n_state    = gmc_pkg::S_BT_RD;
            end
            gmc_pkg::S_EM_WAIT: begin
                if (w_m_acc) begin
                    n_ovalid = 1'b0;
                    if (r_cnt == '0) begin
                        n_state = gmc_pkg::S_IDLE;
                    end else begin
                        w_ch_raddr = AW'(r_cnt - CW'(1));
                        n_state    = gmc_pkg::S_EM_LD;
                    end
                end
            end
            gmc_pkg::S_EM_LD: begin
                n_o_kind = gmc_pkg::KIND_CELL;
                n_o_pts  = '0;
                n_o_ways = '0;
                n_o_ovf  = 1'b0;
                n_o_cell = r_ch_q;
                n_o_last = (r_cnt == CW'(1));
                n_cnt    = r_cnt - CW'(1);
                n_ovalid = 1'b1;
                n_state  = gmc_pkg::S_EM_WAIT;
            end
            default: begin
                n_state = gmc_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- output port ----------------
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {1'b0, r_o_cell, r_o_ovf, r_o_ways, r_o_pts};

    // ---------------- assertions ----------------
    a_valid_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == gmc_pkg::S_EM_WAIT))
        else $error("output valid outside emit wait");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_m_acc && r_o_last) |=> (r_state == gmc_pkg::S_IDLE))
        else $error("not idle after last word");

    a_sum_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) && $past(r_state == gmc_pkg::S_BT_RD)
            |-> (r_o_kind == gmc_pkg::KIND_SUMMARY))
        else $error("first word of a case is not a summary");

endmodule
